[hdl/ile_pkg.sv]
package ile_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_HEAD   = 3'd1,
        CMD_TAIL   = 3'd2,
        CMD_BEFORE = 3'd3,
        CMD_DELETE = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] item_value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_value;
        logic [LEN_W-1:0]    list_length;
    } t_rsp;

endpackage

[hdl/ile_if.sv]
interface ile_req_if;
    logic          valid;
    logic          ready;
    ile_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ile_rsp_if;
    logic          valid;
    logic          ready;
    ile_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/indexed_list_engine.sv]
// Channel  | Dir | Fields
// s_req    | in  | command, position, item_value
// m_rsp    | out | status, read_value, list_length
// Delete and insert shift the entries one at a time through the single
// read/write port pair of the store (read one entry, write it one place
// along, next entry), so their run grows with the number of shifted entries.
// Synchronous active-low reset clears the count and handshake state; the store
// is not cleared. A new command is taken once the result beat has left.
module indexed_list_engine #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ile_req_if.sink   s_req,
    ile_rsp_if.source m_rsp
);
    localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned IW     = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RD_WAIT, S_SH_RD, S_SH_WR, S_PUT, S_RESP
    } t_state;

    t_state                      r_state;
    logic [CNT_W-1:0]            r_count;
    logic [IW-1:0]               r_idx;
    logic [IW-1:0]               r_end;
    logic                        r_up;
    logic [ile_pkg::DATA_W-1:0]  r_val;
    ile_pkg::t_rsp               r_rsp;

    t_state                      n_state;
    ile_pkg::t_status            n_status;
    logic                        n_up;
    logic [IW-1:0]               n_idx;
    logic [IW-1:0]               n_end;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ile_pkg::DATA_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [ile_pkg::DATA_W-1:0]  ram_rdata;

    logic [IW-1:0] cnt_x, pos_x;
    assign cnt_x = IW'(r_count);
    assign pos_x = IW'(s_req.payload.position);

    ile_ram #(.DEPTH(CAPACITY), .ADDR_W(ADDR_W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[ADDR_W-1:0];
        if (r_state == S_IDLE) begin
            ram_raddr = pos_x[ADDR_W-1:0];
        end else if (r_state == S_SH_RD) begin
            // up: read idx-1 ; down: read idx+1
            ram_raddr = r_up ? ADDR_W'(r_idx - 1'b1) : ADDR_W'(r_idx + 1'b1);
        end else if (r_state == S_SH_WR) begin
            ram_we = 1'b1;
        end else if (r_state == S_PUT) begin
            ram_we    = 1'b1;
            ram_wdata = r_val;
        end
    end

    // Decode the offered command: status, next state and the shift walk.
    always_comb begin
        n_state  = S_RESP;
        n_status = ile_pkg::ST_DONE;
        n_up     = 1'b1;
        n_idx    = cnt_x;
        n_end    = pos_x;
        unique case (s_req.payload.command) inside
            ile_pkg::CMD_READ: begin
                if (pos_x < cnt_x) n_state = S_RD_WAIT;
                else n_status = ile_pkg::ST_RANGE;
            end
            ile_pkg::CMD_HEAD, ile_pkg::CMD_TAIL, ile_pkg::CMD_BEFORE: begin
                if (s_req.payload.command == ile_pkg::CMD_HEAD)
                    n_end = '0;
                else if (s_req.payload.command == ile_pkg::CMD_TAIL)
                    n_end = cnt_x;
                if (s_req.payload.command == ile_pkg::CMD_BEFORE && pos_x > cnt_x) begin
                    n_status = ile_pkg::ST_RANGE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = ile_pkg::ST_FULL;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            ile_pkg::CMD_DELETE: begin
                n_up  = 1'b0;
                n_idx = pos_x;
                n_end = cnt_x - 1'b1;
                if (pos_x < cnt_x) n_state = S_SH_RD;
                else n_status = ile_pkg::ST_RANGE;
            end
            default: ;
        endcase
    end

    assign s_req.ready   = (r_state == S_IDLE);
    assign m_rsp.valid   = (r_state == S_RESP);
    assign m_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_req.valid) begin
                        r_val             <= s_req.payload.item_value;
                        r_up              <= n_up;
                        r_idx             <= n_idx;
                        r_end             <= n_end;
                        r_rsp.status      <= n_status;
                        r_rsp.read_value  <= '0;
                        r_rsp.list_length <= ile_pkg::LEN_W'(r_count);
                        r_state           <= n_state;
                    end
                end
                S_RD_WAIT: begin
                    r_rsp.read_value <= ram_rdata;
                    r_state          <= S_RESP;
                end
                S_SH_RD: begin
                    if (r_idx == r_end) begin
                        if (r_up) begin
                            r_state <= S_PUT;
                        end else begin
                            r_count           <= r_count - 1'b1;
                            r_rsp.list_length <= ile_pkg::LEN_W'(r_count - 1'b1);
                            r_state           <= S_RESP;
                        end
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    // advance the walk one entry
                    r_idx   <= r_up ? r_idx - 1'b1 : r_idx + 1'b1;
                    r_state <= S_SH_RD;
                end
                S_PUT: begin
                    r_count           <= r_count + 1'b1;
                    r_rsp.list_length <= ile_pkg::LEN_W'(r_count + 1'b1);
                    r_state           <= S_RESP;
                end
                S_RESP: begin
                    if (m_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[hdl/ile_ram.sv]
module ile_ram #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [ile_pkg::DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [ile_pkg::DATA_W-1:0] o_rdata
);
    logic [ile_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [ile_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
